### hdl/tlps_pkg.sv
// tlps_pkg: shared types and constants for the timed level pattern sequencer
// used by tlps_table and timed_level_pattern_sequencer; no dependencies

package tlps_pkg;

    // table geometry; the depth is a power of two so an index wraps by truncation
    localparam int TABLE_PAIRS = 64;
    localparam int IDX_W       = $clog2(TABLE_PAIRS);

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int FIDX_W  = 6;
    localparam int DUR_W   = 32;
    localparam int TPU_W   = 16;
    localparam int POS_W   = 6;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    // duration codes
    localparam logic [DUR_W-1:0] DUR_STOP = 32'hFFFF_FFFF;
    localparam logic [DUR_W-1:0] DUR_LOOP = '0;

    // ticks_per_unit after reset
    localparam logic [TPU_W-1:0] TPU_RESET = 16'd1;

    // input item kinds, carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2
    } op_t;

    // one table pair
    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration;
    } pair_t;

endpackage

### hdl/tlps_table.sv
// tlps_table: pattern table storage, one write port and two registered read ports
// depends on tlps_pkg for the pair type and table geometry

module tlps_table (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [tlps_pkg::IDX_W-1:0] wr_addr,
    input  tlps_pkg::pair_t         wr_pair,
    input  logic                    rd_a_en,
    input  logic [tlps_pkg::IDX_W-1:0] rd_a_addr,
    output tlps_pkg::pair_t         rd_a_pair,
    input  logic [tlps_pkg::IDX_W-1:0] rd_b_addr,
    output tlps_pkg::pair_t         rd_b_pair
);

    tlps_pkg::pair_t mem [tlps_pkg::TABLE_PAIRS];
    tlps_pkg::pair_t rd_a_reg;
    tlps_pkg::pair_t rd_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_pair;
        end
    end

    // read port a, loaded only when asked; read-first against a same-edge write
    always_ff @(posedge aclk) begin
        if (rd_a_en) begin
            rd_a_reg <= mem[rd_a_addr];
        end
    end

    // read port b, reloaded every cycle
    always_ff @(posedge aclk) begin
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rd_a_pair = rd_a_reg;
    assign rd_b_pair = rd_b_reg;

endmodule

### hdl/timed_level_pattern_sequencer.sv
// timed_level_pattern_sequencer: top level, drives one pin from a table of level/duration pairs
// depends on tlps_pkg and tlps_table
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  tuser: opcode; tdata: index, level, duration
//  m_        out        m_tvalid / m_tready  tdata: pin_on, running, position
//  cfg_      in         cfg_wr_en            cfg_wr_data: ticks_per_unit
//
// one item per cycle unless m_ stalls; an item's result reaches m_ through the work stage
// (table read at the transfer, sequencer update into the output register as it advances)
// the table read and the duration-to-ticks multiply set the cycle time
// reset: aresetn low for one clock clears all control state, the table is not cleared
// a stalled result holds in the output register while one more item waits in the work stage

module timed_level_pattern_sequencer (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [tlps_pkg::TPU_W-1:0]   cfg_wr_data,   // ticks_per_unit
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tlps_pkg::S_DATA_W-1:0] s_tdata,      // entry_index[5:0], entry_level[6],
                                                         // entry_duration[38:7], zero[39]
    input  logic [tlps_pkg::OP_W-1:0]    s_tuser,       // opcode[1:0]
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tlps_pkg::M_DATA_W-1:0] m_tdata       // pin_on[0], running[1], position[7:2]
);

    localparam int IDX_W = tlps_pkg::IDX_W;
    localparam int DUR_W = tlps_pkg::DUR_W;
    localparam int TPU_W = tlps_pkg::TPU_W;
    localparam int PROD_W = DUR_W + TPU_W;

    // next index with wrap at the table end
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(tlps_pkg::TABLE_PAIRS - 1)) begin
            r = '0;
        end else begin
            r = i + IDX_W'(1);
        end
        return r;
    endfunction

    // input field unpacking
    logic [IDX_W-1:0]  in_idx;
    logic              in_level;
    logic [DUR_W-1:0]  in_dur;
    tlps_pkg::op_t     in_op;
    logic              s_xfer;

    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_level = s_tdata[tlps_pkg::FIDX_W];
    assign in_dur   = s_tdata[tlps_pkg::FIDX_W+1 +: DUR_W];
    assign in_op    = tlps_pkg::op_t'(s_tuser);
    assign s_xfer   = s_tvalid && s_tready;

    // registers
    logic [TPU_W-1:0]   tpu_reg;
    logic               s1_valid_reg;
    tlps_pkg::op_t      s1_op_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    tlps_pkg::pair_t    s1_pair_reg;
    logic               active_reg, active_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [DUR_W-1:0]   cd_reg, cd_next;
    logic               pin_reg, pin_next;
    tlps_pkg::pair_t    start_pair_reg, start_pair_next;
    logic               out_valid_reg;
    logic [tlps_pkg::M_DATA_W-1:0] out_data_reg;

    logic               advance;
    tlps_pkg::pair_t    wr_pair;
    tlps_pkg::pair_t    rd_a_pair;
    tlps_pkg::pair_t    rd_b_pair;

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign wr_pair  = '{level: in_level, duration: in_dur};

    // table: written and read at the input transfer, port b follows the fetch position
    tlps_table u_table (
        .aclk      (aclk),
        .wr_en     (s_xfer && (in_op == tlps_pkg::OP_WRITE)),
        .wr_addr   (in_idx),
        .wr_pair   (wr_pair),
        .rd_a_en   (s_xfer),
        .rd_a_addr (in_idx),
        .rd_a_pair (rd_a_pair),
        .rd_b_addr (pos_next),
        .rd_b_pair (rd_b_pair)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= tlps_pkg::TPU_RESET;
        end else if (cfg_wr_en) begin
            tpu_reg <= cfg_wr_data;
        end
    end

    // work stage capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_op_reg   <= in_op;
            s1_idx_reg  <= in_idx;
            s1_pair_reg <= wr_pair;
        end
    end

    // expiry detection and loop selection
    logic             tick_hit;
    logic             expire;
    logic             fetch_loop;
    logic [DUR_W-1:0] mul_dur;
    logic [PROD_W-1:0] product;
    logic [DUR_W-1:0] ticks;

    assign tick_hit   = (s1_op_reg == tlps_pkg::OP_TICK) && (cd_reg != '0);
    assign expire     = tick_hit && (cd_reg == DUR_W'(1));
    assign fetch_loop = rd_b_pair.duration == tlps_pkg::DUR_LOOP;

    // duration to ticks, saturating at the countdown width
    always_comb begin
        if (s1_op_reg == tlps_pkg::OP_START) begin
            mul_dur = rd_a_pair.duration;
        end else if (fetch_loop) begin
            mul_dur = start_pair_reg.duration;
        end else begin
            mul_dur = rd_b_pair.duration;
        end
    end

    assign product = PROD_W'(mul_dur) * PROD_W'(tpu_reg);
    assign ticks   = (product[PROD_W-1:DUR_W] != '0) ? tlps_pkg::DUR_STOP : product[DUR_W-1:0];

    // sequencer next state
    always_comb begin
        active_next     = active_reg;
        start_next      = start_reg;
        pos_next        = pos_reg;
        cd_next         = cd_reg;
        pin_next        = pin_reg;
        start_pair_next = start_pair_reg;
        if (advance) begin
            case (s1_op_reg)
                tlps_pkg::OP_WRITE: begin
                    // keep the cached start pair coherent with table writes
                    if (s1_idx_reg == start_reg) begin
                        start_pair_next = s1_pair_reg;
                    end
                end
                tlps_pkg::OP_START: begin
                    if (!(active_reg && (start_reg == s1_idx_reg))) begin
                        active_next     = 1'b1;
                        start_next      = s1_idx_reg;
                        start_pair_next = rd_a_pair;
                        pin_next        = rd_a_pair.level;
                        cd_next         = ticks;
                        pos_next        = idx_inc(s1_idx_reg);
                    end
                end
                tlps_pkg::OP_TICK: begin
                    if (tick_hit) begin
                        cd_next = cd_reg - DUR_W'(1);
                    end
                    if (expire) begin
                        if (active_reg) begin
                            if (rd_b_pair.duration == tlps_pkg::DUR_STOP) begin
                                pin_next    = rd_b_pair.level;
                                cd_next     = '0;
                                active_next = 1'b0;
                                pos_next    = idx_inc(pos_reg);
                            end else if (fetch_loop) begin
                                pin_next = start_pair_reg.level;
                                cd_next  = ticks;
                                pos_next = idx_inc(start_reg);
                            end else begin
                                pin_next = rd_b_pair.level;
                                cd_next  = ticks;
                                pos_next = idx_inc(pos_reg);
                            end
                        end else begin
                            pin_next = 1'b0;
                        end
                    end
                end
                default: begin
                    // unused opcode leaves the state alone
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            start_reg  <= '0;
            pos_reg    <= '0;
            cd_reg     <= '0;
            pin_reg    <= 1'b0;
        end else begin
            active_reg <= active_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            cd_reg     <= cd_next;
            pin_reg    <= pin_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_pair_reg <= start_pair_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {tlps_pkg::POS_W'(pos_next), active_next, pin_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
